// ===== rtl/core/euler_zxy_to_rotation_matrix_macros.svh =====
// Assertion helpers for the ZXY Euler to rotation matrix block.
`ifndef EULER_ZXY_TO_ROTATION_MATRIX_MACROS_SVH
`define EULER_ZXY_TO_ROTATION_MATRIX_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define EUZXY_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("euzxy: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define EUZXY_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("euzxy: next-cycle check failed");

`endif

// ===== rtl/core/euzxy_pkg.sv =====
package euzxy_pkg;

    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_FRAC_BITS   = 14;

    localparam int ANGLE_W = 16;
    localparam int ENTRY_W = 16;

    // angle to phase: round(angle * 2^32 / 2pi), kept modulo 2^32
    localparam int PHASE_SHIFT = 16 + ANGLE_FRAC_BITS;
    localparam int PROD_W      = PHASE_SHIFT + 32;
    localparam logic signed [47:0] PHASE_SCALE = 48'sd44798133900177;

    localparam int CORDIC_STEPS = 28;
    localparam logic signed [31:0] CORDIC_GAIN_INV = 32'sd652032874;

    typedef logic signed [31:0] t_trig;
    typedef logic signed [63:0] t_prod;
    typedef logic signed [32:0] t_ent;

    localparam t_trig ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005
    };

    // quadrant codes of the phase
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // sine and cosine unit: phase multiply, quadrant fold, CORDIC steps, unfold
    localparam int SC_LATENCY = CORDIC_STEPS + 3;
    // plus raw pair products, rounding, raw triples, combine
    localparam int PIPE_DEPTH = SC_LATENCY + 4;

    localparam int OUT_SHIFT = 30 - OUT_FRAC_BITS;
    localparam int OUT_HALF  = (OUT_SHIFT > 0) ? (1 << (OUT_SHIFT - 1)) : 0;
    localparam int OUT_LIM   = ((1 << OUT_FRAC_BITS) > 32767) ? 32767
                                                              : (1 << OUT_FRAC_BITS);

    typedef struct packed {
        t_trig cos_v;
        t_trig sin_v;
    } t_sincos;

    typedef struct packed {
        logic signed [ENTRY_W-1:0] r00;
        logic signed [ENTRY_W-1:0] r01;
        logic signed [ENTRY_W-1:0] r02;
        logic signed [ENTRY_W-1:0] r10;
        logic signed [ENTRY_W-1:0] r11;
        logic signed [ENTRY_W-1:0] r12;
        logic signed [ENTRY_W-1:0] r20;
        logic signed [ENTRY_W-1:0] r21;
        logic signed [ENTRY_W-1:0] r22;
    } t_mat;

    // Q1.30 x Q1.30 product back to Q1.30, round half up
    function automatic t_trig mul_round(input t_prod p);
        t_prod t;
        t = p + (64'sd1 <<< 29);
        return t[61:30];
    endfunction

    // Q1.30 entry to output format with round half up and symmetric clamp
    function automatic logic signed [ENTRY_W-1:0] to_out(input t_ent v);
        logic signed [33:0] t;
        t = 34'(v) + 34'(OUT_HALF);
        t = t >>> OUT_SHIFT;
        if (t > $signed(34'(OUT_LIM))) begin
            t = $signed(34'(OUT_LIM));
        end else if (t < -$signed(34'(OUT_LIM))) begin
            t = -$signed(34'(OUT_LIM));
        end
        return t[ENTRY_W-1:0];
    endfunction

endpackage

// ===== rtl/core/euzxy_angle_if.sv =====
interface euzxy_angle_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [euzxy_pkg::ANGLE_W-1:0]     angle_x;
    logic signed [euzxy_pkg::ANGLE_W-1:0]     angle_y;
    logic signed [euzxy_pkg::ANGLE_W-1:0]     angle_z;

    modport source (output valid, output angle_x, output angle_y, output angle_z,
                    input ready);
    modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                    output ready);
endinterface

// ===== rtl/core/euzxy_matrix_if.sv =====
interface euzxy_matrix_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r00;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r01;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r02;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r10;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r11;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r12;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r20;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r21;
    logic signed [euzxy_pkg::ENTRY_W-1:0]     r22;

    modport source (output valid, output r00, output r01, output r02, output r10,
                    output r11, output r12, output r20, output r21, output r22,
                    input ready);
    modport sink   (input valid, input r00, input r01, input r02, input r10,
                    input r11, input r12, input r20, input r21, input r22,
                    output ready);
endinterface

// ===== rtl/core/euzxy_sincos.sv =====
module euzxy_sincos (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [euzxy_pkg::ANGLE_W-1:0]   i_angle,
    output euzxy_pkg::t_sincos                     o_sc
);

    localparam int N = euzxy_pkg::CORDIC_STEPS;

    logic signed [euzxy_pkg::PROD_W-1:0] r_prod;
    logic signed [euzxy_pkg::PROD_W-1:0] w_phase_sum;
    logic [31:0]                         w_phase;
    logic [1:0]                          n_q0;
    logic [31:0]                         n_z0;
    logic [1:0]                          r_q0;
    euzxy_pkg::t_trig                    r_z0;

    euzxy_pkg::t_trig r_x [N];
    euzxy_pkg::t_trig r_y [N];
    euzxy_pkg::t_trig r_z [N];
    logic [1:0]       r_q [N];

    euzxy_pkg::t_sincos n_sc;
    euzxy_pkg::t_sincos r_sc;

    // angle times 2^48/2pi, low bits only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= euzxy_pkg::PROD_W'(i_angle) * euzxy_pkg::PROD_W'(euzxy_pkg::PHASE_SCALE);
        end
    end

    // round to a 32-bit phase, fold into the nearest quadrant
    always_comb begin
        w_phase_sum = r_prod + (euzxy_pkg::PROD_W'(1) <<< (euzxy_pkg::PHASE_SHIFT - 1));
        w_phase     = w_phase_sum[euzxy_pkg::PHASE_SHIFT +: 32];
        n_q0        = w_phase[31:30] + {1'b0, w_phase[29]};
        n_z0        = w_phase - {n_q0, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0 <= n_q0;
            r_z0 <= $signed(n_z0);
        end
    end

    // one rotation step per stage
    for (genvar i = 0; i < N; i++) begin : g_step
        euzxy_pkg::t_trig w_x, w_y, w_z;
        logic [1:0]       w_q;
        euzxy_pkg::t_trig n_x, n_y, n_z;

        if (i == 0) begin : g_first
            assign w_x = euzxy_pkg::CORDIC_GAIN_INV;
            assign w_y = '0;
            assign w_z = r_z0;
            assign w_q = r_q0;
        end else begin : g_rest
            assign w_x = r_x[i-1];
            assign w_y = r_y[i-1];
            assign w_z = r_z[i-1];
            assign w_q = r_q[i-1];
        end

        always_comb begin
            if (!w_z[31]) begin
                n_x = w_x - (w_y >>> i);
                n_y = w_y + (w_x >>> i);
                n_z = w_z - euzxy_pkg::ATAN_TAB[i];
            end else begin
                n_x = w_x + (w_y >>> i);
                n_y = w_y - (w_x >>> i);
                n_z = w_z + euzxy_pkg::ATAN_TAB[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i] <= n_x;
                r_y[i] <= n_y;
                r_z[i] <= n_z;
                r_q[i] <= w_q;
            end
        end
    end

    // unfold the quadrant
    always_comb begin
        unique case (r_q[N-1])
            euzxy_pkg::QUAD_0: begin
                n_sc.cos_v = r_x[N-1];
                n_sc.sin_v = r_y[N-1];
            end
            euzxy_pkg::QUAD_1: begin
                n_sc.cos_v = -r_y[N-1];
                n_sc.sin_v = r_x[N-1];
            end
            euzxy_pkg::QUAD_2: begin
                n_sc.cos_v = -r_x[N-1];
                n_sc.sin_v = -r_y[N-1];
            end
            default: begin
                n_sc.cos_v = r_y[N-1];
                n_sc.sin_v = -r_x[N-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sc <= n_sc;
        end
    end

    assign o_sc = r_sc;

endmodule

// ===== rtl/core/euler_zxy_to_rotation_matrix.sv =====
// Each accepted angle request passes through the datapath and the output register to o_matrix.
// Throughput: one request per cycle; the 35-stage datapath (phase multiply,
// quadrant fold, 28 CORDIC stages, unfold, 4 product stages) advances as a whole
// and stalls only while the output skid entry is occupied.
// Reset: i_rst_n synchronous active low; clears all valid bits, including the output
// register and skid valid flags. Datapath registers are not reset.
`include "euler_zxy_to_rotation_matrix_macros.svh"

module euler_zxy_to_rotation_matrix (
    input  logic            i_clk,
    input  logic            i_rst_n,
    euzxy_angle_if.sink     i_angle,
    euzxy_matrix_if.source  o_matrix
);

    localparam int DEPTH = euzxy_pkg::PIPE_DEPTH;

    // ---------------------------------------------------------------
    // Flow control: the whole datapath moves while the skid entry is
    // free. A result arriving while the output register is stalled
    // parks in the skid entry, which then holds the pipe until it drains.
    // ---------------------------------------------------------------
    logic             w_en;
    logic             w_in_fire;
    logic             w_last_vld;
    logic [DEPTH-1:0] r_vld;
    logic             r_out_vld, n_out_vld;
    logic             r_skid_vld, n_skid_vld;

    assign w_en          = !r_skid_vld;
    assign i_angle.ready = w_en;
    assign w_in_fire     = i_angle.valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], w_in_fire};
        end
    end

    assign w_last_vld = r_vld[DEPTH-1] && w_en;

    // ---------------------------------------------------------------
    // Sine and cosine of each angle, one unit per angle
    // ---------------------------------------------------------------
    euzxy_pkg::t_sincos w_scx, w_scy, w_scz;

    euzxy_sincos u_sc_x (.i_clk(i_clk), .i_en(w_en), .i_angle(i_angle.angle_x), .o_sc(w_scx));
    euzxy_sincos u_sc_y (.i_clk(i_clk), .i_en(w_en), .i_angle(i_angle.angle_y), .o_sc(w_scy));
    euzxy_sincos u_sc_z (.i_clk(i_clk), .i_en(w_en), .i_angle(i_angle.angle_z), .o_sc(w_scz));

    // ---------------------------------------------------------------
    // Stage 1: raw pair products
    // ---------------------------------------------------------------
    euzxy_pkg::t_prod r1_szsx, r1_czsx, r1_czcy, r1_szcx, r1_czsy;
    euzxy_pkg::t_prod r1_szcy, r1_czcx, r1_szsy, r1_cxsy, r1_cxcy;
    euzxy_pkg::t_trig r1_sx, r1_sy, r1_cy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_szsx <= 64'(w_scz.sin_v) * 64'(w_scx.sin_v);
            r1_czsx <= 64'(w_scz.cos_v) * 64'(w_scx.sin_v);
            r1_czcy <= 64'(w_scz.cos_v) * 64'(w_scy.cos_v);
            r1_szcx <= 64'(w_scz.sin_v) * 64'(w_scx.cos_v);
            r1_czsy <= 64'(w_scz.cos_v) * 64'(w_scy.sin_v);
            r1_szcy <= 64'(w_scz.sin_v) * 64'(w_scy.cos_v);
            r1_czcx <= 64'(w_scz.cos_v) * 64'(w_scx.cos_v);
            r1_szsy <= 64'(w_scz.sin_v) * 64'(w_scy.sin_v);
            r1_cxsy <= 64'(w_scx.cos_v) * 64'(w_scy.sin_v);
            r1_cxcy <= 64'(w_scx.cos_v) * 64'(w_scy.cos_v);
            r1_sx   <= w_scx.sin_v;
            r1_sy   <= w_scy.sin_v;
            r1_cy   <= w_scy.cos_v;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: round pair products back to Q1.30
    // ---------------------------------------------------------------
    euzxy_pkg::t_trig r2_szsx, r2_czsx, r2_czcy, r2_szcx, r2_czsy;
    euzxy_pkg::t_trig r2_szcy, r2_czcx, r2_szsy, r2_cxsy, r2_cxcy;
    euzxy_pkg::t_trig r2_sx, r2_sy, r2_cy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_szsx <= euzxy_pkg::mul_round(r1_szsx);
            r2_czsx <= euzxy_pkg::mul_round(r1_czsx);
            r2_czcy <= euzxy_pkg::mul_round(r1_czcy);
            r2_szcx <= euzxy_pkg::mul_round(r1_szcx);
            r2_czsy <= euzxy_pkg::mul_round(r1_czsy);
            r2_szcy <= euzxy_pkg::mul_round(r1_szcy);
            r2_czcx <= euzxy_pkg::mul_round(r1_czcx);
            r2_szsy <= euzxy_pkg::mul_round(r1_szsy);
            r2_cxsy <= euzxy_pkg::mul_round(r1_cxsy);
            r2_cxcy <= euzxy_pkg::mul_round(r1_cxcy);
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_cy   <= r1_cy;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: raw triple products; carry single products along
    // ---------------------------------------------------------------
    euzxy_pkg::t_prod r3_szsx_sy, r3_szsx_cy, r3_czsx_sy, r3_czsx_cy;
    euzxy_pkg::t_trig r3_czcy, r3_szcx, r3_czsy, r3_szcy, r3_czcx;
    euzxy_pkg::t_trig r3_szsy, r3_cxsy, r3_cxcy, r3_sx;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_szsx_sy <= 64'(r2_szsx) * 64'(r2_sy);
            r3_szsx_cy <= 64'(r2_szsx) * 64'(r2_cy);
            r3_czsx_sy <= 64'(r2_czsx) * 64'(r2_sy);
            r3_czsx_cy <= 64'(r2_czsx) * 64'(r2_cy);
            r3_czcy    <= r2_czcy;
            r3_szcx    <= r2_szcx;
            r3_czsy    <= r2_czsy;
            r3_szcy    <= r2_szcy;
            r3_czcx    <= r2_czcx;
            r3_szsy    <= r2_szsy;
            r3_cxsy    <= r2_cxsy;
            r3_cxcy    <= r2_cxcy;
            r3_sx      <= r2_sx;
        end
    end

    // ---------------------------------------------------------------
    // Stage 4: round triples and combine into the nine entries (Q1.30)
    // ---------------------------------------------------------------
    euzxy_pkg::t_ent r4_v00, r4_v01, r4_v02, r4_v10, r4_v11;
    euzxy_pkg::t_ent r4_v12, r4_v20, r4_v21, r4_v22;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_v00 <= 33'(r3_czcy) - 33'(euzxy_pkg::mul_round(r3_szsx_sy));
            r4_v01 <= -33'(r3_szcx);
            r4_v02 <= 33'(r3_czsy) + 33'(euzxy_pkg::mul_round(r3_szsx_cy));
            r4_v10 <= 33'(r3_szcy) + 33'(euzxy_pkg::mul_round(r3_czsx_sy));
            r4_v11 <= 33'(r3_czcx);
            r4_v12 <= 33'(r3_szsy) - 33'(euzxy_pkg::mul_round(r3_czsx_cy));
            r4_v20 <= -33'(r3_cxsy);
            r4_v21 <= 33'(r3_sx);
            r4_v22 <= 33'(r3_cxcy);
        end
    end

    // ---------------------------------------------------------------
    // Output rounding and clamp, then output register plus skid entry
    // ---------------------------------------------------------------
    euzxy_pkg::t_mat w_result;

    always_comb begin
        w_result.r00 = euzxy_pkg::to_out(r4_v00);
        w_result.r01 = euzxy_pkg::to_out(r4_v01);
        w_result.r02 = euzxy_pkg::to_out(r4_v02);
        w_result.r10 = euzxy_pkg::to_out(r4_v10);
        w_result.r11 = euzxy_pkg::to_out(r4_v11);
        w_result.r12 = euzxy_pkg::to_out(r4_v12);
        w_result.r20 = euzxy_pkg::to_out(r4_v20);
        w_result.r21 = euzxy_pkg::to_out(r4_v21);
        w_result.r22 = euzxy_pkg::to_out(r4_v22);
    end

    logic            w_load_out, w_load_skid, w_skid_to_out;
    euzxy_pkg::t_mat r_out, r_skid;

    always_comb begin
        n_out_vld     = r_out_vld;
        n_skid_vld    = r_skid_vld;
        w_load_out    = 1'b0;
        w_load_skid   = 1'b0;
        w_skid_to_out = 1'b0;
        if (!r_out_vld || o_matrix.ready) begin
            // output slot frees up: drain the skid entry first
            if (r_skid_vld) begin
                w_skid_to_out = 1'b1;
                n_skid_vld    = 1'b0;
                n_out_vld     = 1'b1;
            end else begin
                w_load_out = w_last_vld;
                n_out_vld  = w_last_vld;
            end
        end else if (w_last_vld) begin
            // output stalled: park the arriving result
            w_load_skid = 1'b1;
            n_skid_vld  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_skid_to_out) begin
            r_out <= r_skid;
        end else if (w_load_out) begin
            r_out <= w_result;
        end
        if (w_load_skid) begin
            r_skid <= w_result;
        end
    end

    assign o_matrix.valid = r_out_vld;
    assign o_matrix.r00   = r_out.r00;
    assign o_matrix.r01   = r_out.r01;
    assign o_matrix.r02   = r_out.r02;
    assign o_matrix.r10   = r_out.r10;
    assign o_matrix.r11   = r_out.r11;
    assign o_matrix.r12   = r_out.r12;
    assign o_matrix.r20   = r_out.r20;
    assign o_matrix.r21   = r_out.r21;
    assign o_matrix.r22   = r_out.r22;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // the skid entry is only ever occupied behind a full output register
    `EUZXY_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    // the skid entry fills only when the output register was stalled
    `EUZXY_ASSERT_NOW(a_skid_fill_cause, i_clk, i_rst_n, $rose(r_skid_vld),
        $past(r_out_vld) && !$past(o_matrix.ready))
    // a taken output with a parked result hands that result over at once
    `EUZXY_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n,
        r_out_vld && o_matrix.ready && r_skid_vld, r_out_vld && !r_skid_vld)
    // entry r21 stays inside the clamp range
    `EUZXY_ASSERT_NOW(a_entry_clamp, i_clk, i_rst_n, r_out_vld,
        (r_out.r21 <= $signed(16'(euzxy_pkg::OUT_LIM)))
        && (r_out.r21 >= -$signed(16'(euzxy_pkg::OUT_LIM))))

endmodule
